// File: hw/rtl/pmre_pkg.sv
// shared types, constants and tables of the period midrange rpm estimator
`timescale 1ns / 1ps

package pmre_pkg;

    // sizes
    localparam int WINDOW_LEN_DEF  = 32;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int SINE_LEN        = 64;
    localparam int PHASE_W         = 6;
    localparam int PERIOD_W        = 32;
    localparam int NUMER_W         = 36;
    localparam int SETPOINT_W      = 16;
    localparam int DIV_W           = 40;
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 36;

    // arithmetic constants
    localparam logic [NUMER_W-1:0] NUMER_RESET   = 36'd18000000000;
    localparam logic [7:0]         SCALE_MUL     = 8'd173;
    localparam logic [31:0]        SCALE_OFS     = 32'd9050;
    localparam logic [13:0]        RPM_FULL      = 14'd10000;
    localparam logic [16:0]        SETPOINT_FULL = 17'd65535;
    localparam logic [15:0]        TOL_RECIP     = 16'd52429;
    localparam int                 TOL_SHIFT     = 19;
    // ceil(2^34 / 5), exact divide by 5 for any 32 bit value after a shift by 34
    localparam logic [31:0]        RECIP5        = 32'hCCCCCCCD;
    // 173 * ceil(2^16 / 20), exact for 173 * r / 20 with r below 20
    localparam logic [23:0]        FRAC_MUL      = 24'd566921;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SPEED = 2'd0,
        CFG_SINE  = 2'd1,
        CFG_NUMER = 2'd2
    } cfg_idx_t;

    // configuration seen by the back end
    typedef struct packed {
        logic [SETPOINT_W-1:0] speed_setpoint;
        logic                  sine_mode;
        logic [NUMER_W-1:0]    rpm_numerator;
    } cfg_t;

    // one result word
    typedef struct packed {
        logic [31:0] filtered_period;
        logic [31:0] rpm_value;
        logic [31:0] scaled_rpm;
        logic        in_tolerance;
        logic [31:0] drive_word;
        logic        last_result;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

    // one period of a 12 bit sine
    localparam logic [11:0] SINE_ROM [SINE_LEN] = '{
        12'd2048, 12'd2248, 12'd2447, 12'd2642, 12'd2831, 12'd3013, 12'd3185, 12'd3347,
        12'd3496, 12'd3631, 12'd3751, 12'd3854, 12'd3940, 12'd4007, 12'd4056, 12'd4085,
        12'd4095, 12'd4085, 12'd4056, 12'd4007, 12'd3940, 12'd3854, 12'd3751, 12'd3631,
        12'd3496, 12'd3347, 12'd3185, 12'd3013, 12'd2831, 12'd2642, 12'd2447, 12'd2248,
        12'd2048, 12'd1847, 12'd1648, 12'd1453, 12'd1264, 12'd1082, 12'd910,  12'd748,
        12'd599,  12'd464,  12'd344,  12'd241,  12'd155,  12'd88,   12'd39,   12'd10,
        12'd0,    12'd10,   12'd39,   12'd88,   12'd155,  12'd241,  12'd344,  12'd464,
        12'd599,  12'd748,  12'd910,  12'd1082, 12'd1264, 12'd1453, 12'd1648, 12'd1847
    };

endpackage

// File: hw/rtl/pmre_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module pmre_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// File: hw/rtl/pmre_fifo.sv
// small register queue between stages
`timescale 1ns / 1ps

module pmre_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    wr_ptr_reg;
    logic [CW-1:0]    cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/pmre_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module pmre_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [pmre_pkg::DIV_W-1:0] dividend,
    input  logic [31:0]               divisor,
    output logic                      done,
    output logic [pmre_pkg::DIV_W-1:0] quotient
);

    localparam int NW = pmre_pkg::DIV_W;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg;
    logic [31:0]   rem_reg;
    logic [31:0]   d_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [32:0]   rem_sh;
    logic [32:0]   rem_sub;
    logic          fits;

    // one trial subtract step
    assign rem_sh  = {rem_reg, q_reg[NW-1]};
    assign rem_sub = rem_sh - {1'b0, d_reg};
    assign fits    = (rem_sh >= {1'b0, d_reg});

    assign done     = done_reg;
    assign quotient = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg    <= '0;
            rem_reg  <= '0;
            d_reg    <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                q_reg    <= dividend;
                rem_reg  <= '0;
                d_reg    <= divisor;
                cnt_reg  <= CW'(NW);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                q_reg   <= {q_reg[NW-2:0], fits};
                rem_reg <= fits ? rem_sub[31:0] : rem_sh[31:0];
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// File: hw/rtl/pmre_front.sv
// front end: takes periods, keeps the window and finds the midrange
`timescale 1ns / 1ps

module pmre_front #(
    parameter int WINDOW_LEN = pmre_pkg::WINDOW_LEN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] period_sample,
    output logic        mq_push,
    input  logic        mq_full,
    output logic [31:0] mq_data
);

    localparam int AW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int CW = $clog2(WINDOW_LEN + 1);

    typedef enum logic [1:0] {
        F_IDLE,
        F_SCAN,
        F_PUSH
    } fstate_t;

    fstate_t       state_reg;
    logic [AW-1:0] wp_reg;
    logic [CW-1:0] fill_reg;
    logic [CW-1:0] cnt_reg;
    logic          rdv_reg;
    logic [31:0]   lo_reg;
    logic [31:0]   hi_reg;
    logic [31:0]   rdata;
    logic          take;
    logic          issue;

    assign full    = (state_reg != F_IDLE);
    assign take    = push && (state_reg == F_IDLE) && (period_sample != '0);
    assign issue   = (state_reg == F_SCAN) && (cnt_reg != fill_reg);
    assign mq_push = (state_reg == F_PUSH) && !mq_full;
    assign mq_data = lo_reg + ((hi_reg - lo_reg) >> 1);

    // period window
    pmre_ram #(
        .WIDTH (32),
        .DEPTH (WINDOW_LEN)
    ) u_window (
        .clk   (clk),
        .we    (take),
        .waddr (wp_reg),
        .wdata (period_sample),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (rdata)
    );

    // ring bookkeeping and min/max scan over the filled entries
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            wp_reg    <= '0;
            fill_reg  <= '0;
            cnt_reg   <= '0;
            rdv_reg   <= 1'b0;
            lo_reg    <= '1;
            hi_reg    <= '0;
        end
        else
        begin
            rdv_reg <= issue;
            case (state_reg)
                F_IDLE:
                begin
                    if (take)
                    begin
                        wp_reg <= (wp_reg == AW'(WINDOW_LEN - 1)) ? '0 : wp_reg + 1'b1;
                        if (fill_reg != CW'(WINDOW_LEN))
                        begin
                            fill_reg <= fill_reg + 1'b1;
                        end
                        cnt_reg   <= '0;
                        lo_reg    <= '1;
                        hi_reg    <= '0;
                        state_reg <= F_SCAN;
                    end
                end
                F_SCAN:
                begin
                    if (issue)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    if (rdv_reg)
                    begin
                        if (rdata < lo_reg)
                        begin
                            lo_reg <= rdata;
                        end
                        if (rdata > hi_reg)
                        begin
                            hi_reg <= rdata;
                        end
                    end
                    else if (!issue)
                    begin
                        state_reg <= F_PUSH;
                    end
                end
                F_PUSH:
                begin
                    if (!mq_full)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/pmre_back.sv
// back end: rpm division, scaling, tolerance check and drive words
`timescale 1ns / 1ps

module pmre_back (
    input  logic              clk,
    input  logic              rst_n,
    input  pmre_pkg::cfg_t    cfg,
    input  logic              mq_empty,
    output logic              mq_pop,
    input  logic [31:0]       mq_data,
    input  logic              oq_full,
    output logic              oq_push,
    output pmre_pkg::result_t oq_data
);

    typedef enum logic [2:0] {
        B_IDLE,
        B_DIV_RPM,
        B_RECIP,
        B_SPLIT,
        B_SCALE,
        B_EMIT
    } bstate_t;

    bstate_t                       state_reg;
    logic [31:0]                   mid_reg;
    logic [31:0]                   rpm_reg;
    logic [27:0]                   quo_reg;
    logic [4:0]                    rest_reg;
    logic [31:0]                   base_reg;
    logic [31:0]                   scaled_reg;
    logic                          inwin_reg;
    logic                          second_reg;
    logic [pmre_pkg::PHASE_W-1:0]  phase_reg;

    // target window pipeline, runs from the configuration alone
    logic [29:0] tprod_reg;
    logic [13:0] target_reg;
    logic [13:0] tol_reg;
    logic [13:0] target_d_reg;
    logic [13:0] low_reg;
    logic [13:0] high_reg;
    logic [13:0] q0;
    logic [30:0] rem0;
    logic [29:0] tol_prod;

    logic                       div_start;
    logic [pmre_pkg::DIV_W-1:0] div_dividend;
    logic [31:0]                div_divisor;
    logic                       div_done;
    logic [pmre_pkg::DIV_W-1:0] div_q;
    logic [63:0]                recip_prod;
    logic [23:0]                frac_prod;
    logic                       last;
    logic                       inwin;

    // divide by 65535 as a shift plus one correction step
    assign q0       = tprod_reg[29:16];
    assign rem0     = {1'b0, tprod_reg} - {1'b0, q0, 16'd0} + 31'(q0);
    assign tol_prod = target_reg * pmre_pkg::TOL_RECIP;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tprod_reg    <= '0;
            target_reg   <= '0;
            tol_reg      <= '0;
            target_d_reg <= '0;
            low_reg      <= '0;
            high_reg     <= '0;
        end
        else
        begin
            tprod_reg    <= cfg.speed_setpoint * pmre_pkg::RPM_FULL;
            target_reg   <= q0 + 14'(rem0 >= 31'(pmre_pkg::SETPOINT_FULL));
            tol_reg      <= 14'(tol_prod >> pmre_pkg::TOL_SHIFT);
            target_d_reg <= target_reg;
            low_reg      <= target_d_reg - tol_reg;
            high_reg     <= target_d_reg + tol_reg;
        end
    end

    // serial divider for numerator by midpoint
    assign div_start    = (state_reg == B_IDLE) && !mq_empty;
    assign div_dividend = {{(pmre_pkg::DIV_W - pmre_pkg::NUMER_W){1'b0}}, cfg.rpm_numerator};
    assign div_divisor  = mq_data;

    pmre_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // rpm / 20 as (rpm >> 2) / 5 by reciprocal, remainder part from a small product
    assign recip_prod = {34'd0, rpm_reg[31:2]} * {32'd0, pmre_pkg::RECIP5};
    assign frac_prod  = {19'd0, rest_reg} * pmre_pkg::FRAC_MUL;

    assign inwin  = ({18'd0, low_reg} <= rpm_reg) && (rpm_reg <= {18'd0, high_reg});
    assign mq_pop = (state_reg == B_IDLE) && !mq_empty;

    // result word
    assign last    = !(inwin_reg && !second_reg);
    assign oq_push = (state_reg == B_EMIT) && !oq_full;
    always_comb
    begin
        oq_data.filtered_period = mid_reg;
        oq_data.rpm_value       = rpm_reg;
        oq_data.scaled_rpm      = scaled_reg;
        oq_data.in_tolerance    = inwin_reg;
        oq_data.drive_word      = cfg.sine_mode ? {20'd0, pmre_pkg::SINE_ROM[phase_reg]}
                                                : scaled_reg;
        oq_data.last_result     = last;
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            mid_reg    <= '0;
            rpm_reg    <= '0;
            quo_reg    <= '0;
            rest_reg   <= '0;
            base_reg   <= '0;
            scaled_reg <= '0;
            inwin_reg  <= 1'b0;
            second_reg <= 1'b0;
            phase_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                B_IDLE:
                begin
                    if (!mq_empty)
                    begin
                        mid_reg   <= mq_data;
                        state_reg <= B_DIV_RPM;
                    end
                end
                B_DIV_RPM:
                begin
                    if (div_done)
                    begin
                        rpm_reg   <= div_q[31:0];
                        state_reg <= B_RECIP;
                    end
                end
                B_RECIP:
                begin
                    quo_reg   <= recip_prod[61:34];
                    state_reg <= B_SPLIT;
                end
                B_SPLIT:
                begin
                    rest_reg  <= 5'(rpm_reg - {2'b0, quo_reg, 2'b0} - {quo_reg, 4'b0});
                    base_reg  <= {4'd0, quo_reg} * 32'(pmre_pkg::SCALE_MUL);
                    state_reg <= B_SCALE;
                end
                B_SCALE:
                begin
                    scaled_reg <= base_reg + {24'd0, frac_prod[23:16]} - pmre_pkg::SCALE_OFS;
                    inwin_reg  <= inwin;
                    second_reg <= 1'b0;
                    state_reg  <= B_EMIT;
                end
                B_EMIT:
                begin
                    if (!oq_full)
                    begin
                        if (cfg.sine_mode)
                        begin
                            phase_reg <= phase_reg + 1'b1;
                        end
                        if (last)
                        begin
                            state_reg <= B_IDLE;
                        end
                        else
                        begin
                            second_reg <= 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/period_midrange_rpm_estimator_unit.sv
// top level of the period midrange rpm estimator
`timescale 1ns / 1ps

// Each nonzero period is written into a ring of WINDOW_LEN entries; the front end then
// scans the filled entries from the window RAM, one per cycle, and passes the midpoint of
// their minimum and maximum through a short queue to the back end. A zero period is accepted
// but gives no word. The front end holds full from each nonzero period until its midpoint
// enters the queue. The back end runs the 40-step pass of its serial divider (numerator by
// midpoint), then the scaling by 173/20, and emits one word, or two when the rpm lies
// within 10% of the target. Results wait in an output queue while the next period is
// already being scanned. Configuration writes are always ready and are registered before
// they take effect, the setpoint also through its target window registers; write them
// only while the block is idle.
module period_midrange_rpm_estimator_unit #(
    parameter int WINDOW_LEN  = pmre_pkg::WINDOW_LEN_DEF,
    parameter int QUEUE_DEPTH = pmre_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // period input
    input  logic                             push,
    output logic                             full,
    input  logic [31:0]                      period_sample,
    // result output
    output logic                             empty,
    input  logic                             pop,
    output logic [31:0]                      filtered_period,
    output logic [31:0]                      rpm_value,
    output logic [31:0]                      scaled_rpm,
    output logic                             in_tolerance,
    output logic [31:0]                      drive_word,
    output logic                             last_result,
    // configuration
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pmre_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pmre_pkg::CFG_DATA_W-1:0]  cfg_data
);

    pmre_pkg::cfg_t    cfg_reg;
    pmre_pkg::result_t out_word;
    pmre_pkg::result_t res_word;

    logic        mq_push;
    logic        mq_full;
    logic [31:0] mq_wdata;
    logic        mq_pop;
    logic        mq_empty;
    logic [31:0] mq_rdata;
    logic        oq_push;
    logic        oq_full;
    logic [pmre_pkg::RESULT_W-1:0] oq_rdata;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.speed_setpoint <= '0;
            cfg_reg.sine_mode      <= 1'b0;
            cfg_reg.rpm_numerator  <= pmre_pkg::NUMER_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                pmre_pkg::CFG_SPEED:
                begin
                    cfg_reg.speed_setpoint <= cfg_data[pmre_pkg::SETPOINT_W-1:0];
                end
                pmre_pkg::CFG_SINE:
                begin
                    cfg_reg.sine_mode <= cfg_data[0];
                end
                pmre_pkg::CFG_NUMER:
                begin
                    cfg_reg.rpm_numerator <= cfg_data[pmre_pkg::NUMER_W-1:0];
                end
                default:
                begin
                    cfg_reg.sine_mode <= cfg_reg.sine_mode;
                end
            endcase
        end
    end

    // window and midrange
    pmre_front #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .period_sample (period_sample),
        .mq_push       (mq_push),
        .mq_full       (mq_full),
        .mq_data       (mq_wdata)
    );

    // midpoint queue
    pmre_fifo #(
        .WIDTH (32),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mq_push),
        .wdata (mq_wdata),
        .full  (mq_full),
        .pop   (mq_pop),
        .rdata (mq_rdata),
        .empty (mq_empty)
    );

    // rpm and drive words
    pmre_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .mq_empty (mq_empty),
        .mq_pop   (mq_pop),
        .mq_data  (mq_rdata),
        .oq_full  (oq_full),
        .oq_push  (oq_push),
        .oq_data  (res_word)
    );

    // result queue
    pmre_fifo #(
        .WIDTH (pmre_pkg::RESULT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (oq_push),
        .wdata (res_word),
        .full  (oq_full),
        .pop   (pop),
        .rdata (oq_rdata),
        .empty (empty)
    );

    assign out_word        = pmre_pkg::result_t'(oq_rdata);
    assign filtered_period = out_word.filtered_period;
    assign rpm_value       = out_word.rpm_value;
    assign scaled_rpm      = out_word.scaled_rpm;
    assign in_tolerance    = out_word.in_tolerance;
    assign drive_word      = out_word.drive_word;
    assign last_result     = out_word.last_result;

endmodule

// File: hw/rtl/pmre_checker.sv
// port level checks of the period midrange rpm estimator and their binding
`timescale 1ns / 1ps

module pmre_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        empty,
    input  logic        pop,
    input  logic [31:0] filtered_period,
    input  logic [31:0] rpm_value,
    input  logic [31:0] scaled_rpm,
    input  logic        in_tolerance,
    input  logic [31:0] drive_word,
    input  logic        last_result
);

    // a word that is not the last of its period only comes from an in-window rpm
    a_first_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !last_result) |-> in_tolerance)
    else $error("non-final word without in_tolerance");

    // the second word of a pair follows at once with the same measurement
    a_pair_matches: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !last_result) |=>
            (!empty && last_result && filtered_period == $past(filtered_period)
             && rpm_value == $past(rpm_value) && scaled_rpm == $past(scaled_rpm)))
    else $error("second word of a pair missing or different");

    // the midpoint of nonzero periods is never zero
    a_mid_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (filtered_period != '0))
    else $error("zero filtered period");

    // the drive word is either the scaled rpm or a 12 bit sine sample
    a_drive_src: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (drive_word == scaled_rpm || drive_word <= 32'd4095))
    else $error("drive word from neither source");

endmodule

bind period_midrange_rpm_estimator_unit pmre_checker u_pmre_checker (.*);

// File: verif/tb_top.sv
// self-checking testbench of the period midrange rpm estimator unit
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int DRAIN_CYCLES  = 200;
    localparam int APPLY_CYCLES  = 16;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 100;
    localparam int WIN_LEN       = pmre_pkg::WINDOW_LEN_DEF;
    localparam int PTR_W         = $clog2(WIN_LEN);
    localparam int NUM_W         = pmre_pkg::NUMER_W;
    localparam int SP_W          = pmre_pkg::SETPOINT_W;
    localparam int IDX_W         = pmre_pkg::CFG_INDEX_W;
    localparam int DAT_W         = pmre_pkg::CFG_DATA_W;

    localparam logic [NUM_W-1:0] NUMER_MAX  = '1;
    localparam logic [IDX_W-1:0] CFG_UNUSED = 2'd3;

    // running model of the ring, filter, rpm math and drive word sequencing
    class rpm_tracker;
        logic [31:0]                    window [WIN_LEN];
        logic [PTR_W-1:0]               wr_ptr;
        int unsigned                    filled;
        logic [pmre_pkg::PHASE_W-1:0]   phase;
        logic [SP_W-1:0]                setpoint;
        logic                           sine_on;
        logic [NUM_W-1:0]               numer;
        pmre_pkg::result_t              expected_words [$];
        int unsigned                    errors;

        function new();
            wr_ptr   = '0;
            filled   = 0;
            phase    = '0;
            setpoint = '0;
            sine_on  = 1'b0;
            numer    = pmre_pkg::NUMER_RESET;
            errors   = 0;
        endfunction

        // register write as accepted on the config channel
        function void write_reg(logic [IDX_W-1:0] idx, logic [DAT_W-1:0] data);
            case (idx)
                pmre_pkg::CFG_SPEED: setpoint = data[SP_W-1:0];
                pmre_pkg::CFG_SINE:  sine_on  = data[0];
                pmre_pkg::CFG_NUMER: numer    = data[NUM_W-1:0];
                default:             ;
            endcase
        endfunction

        // accepted period: update the ring and queue the words it causes
        function void note_period(logic [31:0] sample);
            logic [31:0]       lo, hi, mid, rpm, scaled, target, tol, low, high;
            logic [63:0]       quot, prod;
            bit                hit;
            int                n;
            pmre_pkg::result_t w;
            if (sample == 32'd0)
                return;
            window[wr_ptr] = sample;
            wr_ptr = wr_ptr + 1'b1;
            if (filled < WIN_LEN)
                filled++;

            // midrange over the filled entries only
            lo = '1;
            hi = '0;
            for (int i = 0; i < filled; i++)
            begin
                if (window[PTR_W'(i)] < lo) lo = window[PTR_W'(i)];
                if (window[PTR_W'(i)] > hi) hi = window[PTR_W'(i)];
            end
            mid = lo + (hi - lo) / 2;

            quot   = {28'd0, numer} / {32'd0, mid};
            rpm    = quot[31:0];
            prod   = (64'd173 * {32'd0, rpm}) / 64'd20 - 64'd9050;
            scaled = prod[31:0];

            // tolerance window around the target, lower edge clamped at zero
            target = ({16'd0, setpoint} * 32'd10000) / 32'd65535;
            tol    = target / 32'd10;
            low    = (target > tol) ? target - tol : 32'd0;
            high   = target + tol;
            hit    = (rpm >= low) && (rpm <= high);
            n      = hit ? 2 : 1;

            for (int k = 0; k < n; k++)
            begin
                w.filtered_period = mid;
                w.rpm_value       = rpm;
                w.scaled_rpm      = scaled;
                w.in_tolerance    = hit;
                if (sine_on)
                begin
                    w.drive_word = {20'd0, pmre_pkg::SINE_ROM[phase]};
                    phase = phase + 1'b1;
                end
                else
                begin
                    w.drive_word = scaled;
                end
                w.last_result = (k == n - 1);
                expected_words.push_back(w);
            end
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (act_v !== exp_v)
            begin
                $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        // popped word against the oldest expected one
        function void check_word(pmre_pkg::result_t got);
            pmre_pkg::result_t exp_w;
            if (expected_words.size() == 0)
            begin
                $error("unexpected word: filtered_period %0d rpm_value %0d",
                       got.filtered_period, got.rpm_value);
                errors++;
                return;
            end
            exp_w = expected_words.pop_front();
            compare_field("filtered_period", exp_w.filtered_period, got.filtered_period);
            compare_field("rpm_value", exp_w.rpm_value, got.rpm_value);
            compare_field("scaled_rpm", exp_w.scaled_rpm, got.scaled_rpm);
            compare_field("in_tolerance", 32'(exp_w.in_tolerance), 32'(got.in_tolerance));
            compare_field("drive_word", exp_w.drive_word, got.drive_word);
            compare_field("last_result", 32'(exp_w.last_result), 32'(got.last_result));
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             push = 1'b0;
    logic             full;
    logic [31:0]      period_sample = '0;
    logic             empty;
    logic             pop = 1'b0;
    logic [31:0]      filtered_period;
    logic [31:0]      rpm_value;
    logic [31:0]      scaled_rpm;
    logic             in_tolerance;
    logic [31:0]      drive_word;
    logic             last_result;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [DAT_W-1:0] cfg_data = '0;

    rpm_tracker  tracker = new();
    bit          calm = 1'b0;
    int unsigned cycles = 0;

    period_midrange_rpm_estimator_unit DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .period_sample   (period_sample),
        .empty           (empty),
        .pop             (pop),
        .filtered_period (filtered_period),
        .rpm_value       (rpm_value),
        .scaled_rpm      (scaled_rpm),
        .in_tolerance    (in_tolerance),
        .drive_word      (drive_word),
        .last_result     (last_result),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // handshake monitors on all three channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                tracker.note_period(period_sample);
            if (pop && !empty)
                tracker.check_word(pmre_pkg::result_t'({filtered_period, rpm_value,
                                                        scaled_rpm, in_tolerance,
                                                        drive_word, last_result}));
            if (cfg_valid && cfg_ready)
                tracker.write_reg(cfg_index, cfg_data);
        end
    end

    // result side: random pop bursts and stalls
    initial
    begin
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            else
            begin
                pop <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // one period word, with an optional gap in front of it
    task automatic send_period(input logic [31:0] value);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        push          <= 1'b1;
        period_sample <= value;
        do @(posedge clk); while (full);
    endtask

    task automatic drive_cfg(input logic [IDX_W-1:0] idx, input logic [DAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // drain the block, then rewrite all registers; unused bits carry junk
    task automatic reprogram(input logic [SP_W-1:0] sp, input logic sine,
                             input logic [NUM_W-1:0] num, input bit poke_unused);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        push <= 1'b0;
        while (tracker.expected_words.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        drive_cfg(pmre_pkg::CFG_SPEED, {junk[DAT_W-1:SP_W], sp});
        drive_cfg(pmre_pkg::CFG_SINE, {junk[DAT_W-1:1], sine});
        drive_cfg(pmre_pkg::CFG_NUMER, num);
        if (poke_unused)
            drive_cfg(CFG_UNUSED, junk[DAT_W-1:0]);
        cfg_valid <= 1'b0;
        repeat (APPLY_CYCLES) @(posedge clk);
    endtask

    // one random setting, then periods clustered around the rpm target
    task automatic run_phase(input int items, input bit noisy);
        logic [SP_W-1:0]  sp;
        logic             sine;
        logic [NUM_W-1:0] num;
        logic [63:0]      center, spread, val;
        int unsigned      target, roll;
        int               sent;
        case ($urandom_range(0, 5))
            0:       num = pmre_pkg::NUMER_RESET;
            1:       num = NUMER_MAX;
            2:       num = 36'd1;
            default: num = {4'($urandom), $urandom};
        endcase
        if (num == '0)
            num = 36'd1;
        case ($urandom_range(0, 5))
            0:       sp = '0;
            1:       sp = '1;
            default: sp = 16'($urandom);
        endcase
        sine = 1'($urandom_range(0, 1));
        reprogram(sp, sine, num, 1'($urandom_range(0, 1)));

        target = ({16'd0, sp} * 32'd10000) / 32'd65535;
        if (target == 0)
            center = 64'($urandom_range(1, 32'hFFFFFFFF));
        else
            center = ({28'd0, num} / 64'(target)) * $urandom_range(80, 125) / 100;
        if (center == 0)
            center = 64'd1;
        if (center > 64'hFFFFFFFF)
            center = 64'hFFFFFFFF;
        spread = center / $urandom_range(8, 40);

        sent = 0;
        while (sent < items)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 5)
                val = '0;
            else if (noisy && roll < 7)
                val = 64'($urandom);
            else
                val = center - spread + $urandom_range(0, 32'(2 * spread));
            if (val > 64'hFFFFFFFF)
                val = 64'hFFFFFFFF;
            send_period(val[31:0]);
            if (val != 0)
                sent++;
        end
    endtask

    // main sequence
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset config: extreme periods, truncated rpm, ignored zeros
        send_period(32'd1);
        send_period(32'hFFFFFFFF);
        send_period(32'd0);
        send_period(32'd3600000);
        send_period(32'd2);
        send_period(32'h80000000);
        send_period(32'h7FFFFFFF);
        send_period(32'd0);

        // zero numerator gives rpm zero, in window for a zero target
        reprogram('0, 1'b0, '0, 1'b0);
        send_period(32'd5);
        send_period(32'd100);
        send_period(32'd0);

        // same in sine mode: two sine words per period
        reprogram('0, 1'b1, '0, 1'b1);
        send_period(32'd7);
        send_period(32'd9);

        // full-scale target and numerator
        reprogram('1, 1'b1, NUMER_MAX, 1'b1);
        send_period(32'd1);
        send_period(32'hFFFFFFFF);
        send_period(32'd6871947);

        // smallest nonzero numerator and setpoint
        reprogram(16'd1, 1'b0, 36'd1, 1'b0);
        send_period(32'd3);
        send_period(32'd1);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            calm = (p >= RANDOM_PHASES - 2);
            run_phase(PHASE_ITEMS, (p % 3) == 1);
        end

        // drain and let the pipeline settle
        push <= 1'b0;
        while (tracker.expected_words.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.errors == 0 && tracker.expected_words.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
